// File: src/t2dc_pkg.sv
`default_nettype none

package t2dc_pkg;

    // Fixed-point format and CORDIC depth
    localparam int FRAC_BITS    = 16;   // Q-format fraction bits, 8..24
    localparam int CORDIC_STEPS = 16;   // micro-rotations, 8..24
    localparam int ATAN_ENTRIES = 24;
    localparam int STEP_W       = $clog2(ATAN_ENTRIES);

    // Input register + CORDIC cells + product, sum and output stages
    localparam int LATENCY = CORDIC_STEPS + 4;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;   // 0.6072529350 in Q2.30
    localparam logic signed [63:0] Q30_HALF    = 64'sd536870912;
    localparam logic signed [63:0] Q_HALF      = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] S32_MAX     = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] parent_pos_x;
        logic signed [31:0] parent_pos_y;
        logic signed [31:0] parent_scale_x;
        logic signed [31:0] parent_scale_y;
        logic [15:0]        parent_angle;
        logic signed [31:0] local_pos_x;
        logic signed [31:0] local_pos_y;
        logic signed [31:0] local_scale_x;
        logic signed [31:0] local_scale_y;
        logic [15:0]        local_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] global_pos_x;
        logic signed [31:0] global_pos_y;
        logic signed [31:0] global_scale_x;
        logic signed [31:0] global_scale_y;
        logic [15:0]        global_angle;
        logic               saturated;
    } t_out_item;

    // CORDIC vector and residual angle (2^32 units per turn); flip = half-turn fold
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               flip;
    } t_rot;

    // Values that ride along the CORDIC chain
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] gsx;
        logic signed [31:0] gsy;
        logic signed [31:0] ppx;
        logic signed [31:0] ppy;
        logic [15:0]        ang;
        logic               clip;
    } t_side;

    typedef struct packed {
        logic signed [31:0] val;
        logic               clip;
    } t_sat;

    function automatic logic signed [31:0] atan_turns(input logic [STEP_W-1:0] idx);
        logic signed [31:0] a;
        case (idx)
            5'd0:    a = 32'sd536870912;
            5'd1:    a = 32'sd316933406;
            5'd2:    a = 32'sd167458907;
            5'd3:    a = 32'sd85004756;
            5'd4:    a = 32'sd42667331;
            5'd5:    a = 32'sd21354465;
            5'd6:    a = 32'sd10679838;
            5'd7:    a = 32'sd5340245;
            5'd8:    a = 32'sd2670163;
            5'd9:    a = 32'sd1335087;
            5'd10:   a = 32'sd667544;
            5'd11:   a = 32'sd333772;
            5'd12:   a = 32'sd166886;
            5'd13:   a = 32'sd83443;
            5'd14:   a = 32'sd41722;
            5'd15:   a = 32'sd20861;
            5'd16:   a = 32'sd10430;
            5'd17:   a = 32'sd5215;
            5'd18:   a = 32'sd2608;
            5'd19:   a = 32'sd1304;
            5'd20:   a = 32'sd652;
            5'd21:   a = 32'sd326;
            5'd22:   a = 32'sd163;
            5'd23:   a = 32'sd81;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

    function automatic t_sat sat32(input logic signed [63:0] v);
        t_sat r;
        if (v > S32_MAX) begin
            r.val  = S32_MAX[31:0];
            r.clip = 1'b1;
        end else if (v < S32_MIN) begin
            r.val  = S32_MIN[31:0];
            r.clip = 1'b1;
        end else begin
            r.val  = v[31:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // Round half up, drop FRAC_BITS, saturate
    function automatic t_sat qround(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + Q_HALF) >>> FRAC_BITS;
        return sat32(r);
    endfunction

endpackage

`default_nettype wire

// File: src/transform_2d_compose_core.sv
`default_nettype none

// 2D transform composition: parent global transform + child local transform
// gives the child's global transform.
//
// Input channel: i_item is taken at each rising edge with start high and busy
// low. busy is high only while i_rst_n is asserted, so one transfer can be
// taken every cycle.
// Output channel: o_result is shown for exactly one cycle with o_valid high;
// the receiver has no way to stall it, so no result is ever held back.
//
// Throughput: one item per cycle. In order, the pipeline holds the input
// register, the CORDIC chain with one micro-rotation cell per step, the
// rotation multiplies, the rounding sum and the output register.
//
// Reset (synchronous, active low) clears every valid bit in the pipeline;
// items in flight are dropped and no result follows for them.

module transform_2d_compose_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t2dc_pkg::t_in_item   i_item,
    output logic                      o_valid,
    output t2dc_pkg::t_out_item       o_result
);

    localparam int N = t2dc_pkg::CORDIC_STEPS;

    // ---------------- input stage ----------------
    // Scale products are formed here at full 64-bit width; the fold of the
    // parent angle into [-quarter, +quarter] turn sets up the CORDIC.
    logic               accept;
    logic               r0_valid;
    logic signed [63:0] r0_prod_sx;
    logic signed [63:0] r0_prod_sy;
    logic signed [63:0] r0_prod_gsx;
    logic signed [63:0] r0_prod_gsy;
    logic signed [31:0] r0_ppx;
    logic signed [31:0] r0_ppy;
    logic [15:0]        r0_ang;
    t2dc_pkg::t_rot     r0_rot;

    logic signed [16:0] fold_s;
    logic signed [16:0] fold_r;
    logic               fold_flip;
    t2dc_pkg::t_rot     n0_rot;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    always_comb begin
        fold_s    = {i_item.parent_angle[15], i_item.parent_angle};
        fold_r    = fold_s;
        fold_flip = 1'b0;
        if (fold_s > 17'sd16384) begin
            fold_r    = fold_s - 17'sd32768;
            fold_flip = 1'b1;
        end else if (fold_s < -17'sd16384) begin
            fold_r    = fold_s + 17'sd32768;
            fold_flip = 1'b1;
        end
        // folded angle fits 16 signed bits; 65536 residual units per code
        n0_rot.x    = t2dc_pkg::CORDIC_GAIN;
        n0_rot.y    = 32'sd0;
        n0_rot.z    = {fold_r[15:0], 16'h0000};
        n0_rot.flip = fold_flip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= accept;
        end
        r0_prod_sx  <= 64'(i_item.parent_scale_x) * 64'(i_item.local_pos_x);
        r0_prod_sy  <= 64'(i_item.parent_scale_y) * 64'(i_item.local_pos_y);
        r0_prod_gsx <= 64'(i_item.parent_scale_x) * 64'(i_item.local_scale_x);
        r0_prod_gsy <= 64'(i_item.parent_scale_y) * 64'(i_item.local_scale_y);
        r0_ppx      <= i_item.parent_pos_x;
        r0_ppy      <= i_item.parent_pos_y;
        r0_ang      <= i_item.parent_angle + i_item.local_angle;   // wraps mod one turn
        r0_rot      <= n0_rot;
    end

    // Round and saturate the four Q products; they then ride the chain.
    t2dc_pkg::t_sat  q_sx;
    t2dc_pkg::t_sat  q_sy;
    t2dc_pkg::t_sat  q_gsx;
    t2dc_pkg::t_sat  q_gsy;
    t2dc_pkg::t_side side0;

    always_comb begin
        q_sx       = t2dc_pkg::qround(r0_prod_sx);
        q_sy       = t2dc_pkg::qround(r0_prod_sy);
        q_gsx      = t2dc_pkg::qround(r0_prod_gsx);
        q_gsy      = t2dc_pkg::qround(r0_prod_gsy);
        side0.sx   = q_sx.val;
        side0.sy   = q_sy.val;
        side0.gsx  = q_gsx.val;
        side0.gsy  = q_gsy.val;
        side0.ppx  = r0_ppx;
        side0.ppy  = r0_ppy;
        side0.ang  = r0_ang;
        side0.clip = q_sx.clip | q_sy.clip | q_gsx.clip | q_gsy.clip;
    end

    // ---------------- CORDIC chain ----------------
    logic            ch_valid [N+1];
    t2dc_pkg::t_rot  ch_rot   [N+1];
    t2dc_pkg::t_side ch_side  [N+1];

    assign ch_valid[0] = r0_valid;
    assign ch_rot[0]   = r0_rot;
    assign ch_side[0]  = side0;

    for (genvar k = 0; k < N; k++) begin : g_cell
        t2dc_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (t2dc_pkg::STEP_W'(k)),
            .i_valid (ch_valid[k]),
            .i_rot   (ch_rot[k]),
            .i_side  (ch_side[k]),
            .o_valid (ch_valid[k+1]),
            .o_rot   (ch_rot[k+1]),
            .o_side  (ch_side[k+1])
        );
    end

    // ---------------- rotation multiplies ----------------
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
    t2dc_pkg::t_side    side_n;

    assign side_n = ch_side[N];
    assign cos_v  = ch_rot[N].flip ? -ch_rot[N].x : ch_rot[N].x;
    assign sin_v  = ch_rot[N].flip ? -ch_rot[N].y : ch_rot[N].y;

    logic               r1_valid;
    logic signed [63:0] r1_xc;
    logic signed [63:0] r1_ys;
    logic signed [63:0] r1_yc;
    logic signed [63:0] r1_xs;
    t2dc_pkg::t_side    r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= ch_valid[N];
        end
        r1_xc   <= 64'(side_n.sx) * 64'(cos_v);
        r1_ys   <= 64'(side_n.sy) * 64'(sin_v);
        r1_yc   <= 64'(side_n.sy) * 64'(cos_v);
        r1_xs   <= 64'(side_n.sx) * 64'(sin_v);
        r1_side <= side_n;
    end

    // ---------------- rounding sum, Q16.16 x Q2.30 back to Q16.16 ----------------
    logic               r2_valid;
    logic signed [33:0] r2_ox;
    logic signed [33:0] r2_oy;
    t2dc_pkg::t_side    r2_side;
    logic signed [63:0] sum_x;
    logic signed [63:0] sum_y;

    assign sum_x = (r1_xc + r1_ys + t2dc_pkg::Q30_HALF) >>> 30;
    assign sum_y = (r1_yc - r1_xs + t2dc_pkg::Q30_HALF) >>> 30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_ox   <= sum_x[33:0];
        r2_oy   <= sum_y[33:0];
        r2_side <= r1_side;
    end

    // ---------------- final add, saturate, output register ----------------
    t2dc_pkg::t_sat     g_x;
    t2dc_pkg::t_sat     g_y;
    t2dc_pkg::t_out_item n_out;

    always_comb begin
        g_x = t2dc_pkg::sat32(64'(r2_side.ppx) + 64'(r2_ox));
        g_y = t2dc_pkg::sat32(64'(r2_side.ppy) + 64'(r2_oy));
        n_out.global_pos_x   = g_x.val;
        n_out.global_pos_y   = g_y.val;
        n_out.global_scale_x = r2_side.gsx;
        n_out.global_scale_y = r2_side.gsy;
        n_out.global_angle   = r2_side.ang;
        n_out.saturated      = r2_side.clip | g_x.clip | g_y.clip;
    end

    logic                r_out_valid;
    t2dc_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r2_valid;
        end
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// File: src/t2dc_cordic_cell.sv
`default_nettype none

module t2dc_cordic_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [t2dc_pkg::STEP_W-1:0]   i_step,
    input  wire logic                          i_valid,
    input  wire t2dc_pkg::t_rot                i_rot,
    input  wire t2dc_pkg::t_side               i_side,
    output logic                               o_valid,
    output t2dc_pkg::t_rot                     o_rot,
    output t2dc_pkg::t_side                    o_side
);

    logic             r_valid;
    t2dc_pkg::t_rot   r_rot;
    t2dc_pkg::t_side  r_side;
    t2dc_pkg::t_rot   n_rot;

    logic signed [31:0] x_sh;
    logic signed [31:0] y_sh;
    logic signed [31:0] ang;

    assign x_sh = i_rot.x >>> i_step;
    assign y_sh = i_rot.y >>> i_step;
    assign ang  = t2dc_pkg::atan_turns(i_step);

    // One micro-rotation, direction from the sign of the residual angle
    always_comb begin
        n_rot.flip = i_rot.flip;
        if (i_rot.z >= 0) begin
            n_rot.x = i_rot.x - y_sh;
            n_rot.y = i_rot.y + x_sh;
            n_rot.z = i_rot.z - ang;
        end else begin
            n_rot.x = i_rot.x + y_sh;
            n_rot.y = i_rot.y - x_sh;
            n_rot.z = i_rot.z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rot  <= n_rot;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: src/t2dc_checker.sv
`default_nettype none

module t2dc_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire t2dc_pkg::t_in_item   i_item,
    input wire logic                 o_valid,
    input wire t2dc_pkg::t_out_item  o_result
);

    // every result traces back to a matching input transfer
    a_result_from_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, t2dc_pkg::LATENCY))
        else $error("result without matching input transfer");

    // angle sum wraps and travels with its item
    a_angle_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.global_angle ==
            16'($past(i_item.parent_angle, t2dc_pkg::LATENCY)
                + $past(i_item.local_angle, t2dc_pkg::LATENCY)))
        else $error("global angle mismatch");

    // zero parent x scale gives zero global x scale
    a_zero_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_item.parent_scale_x, t2dc_pkg::LATENCY) == 32'sd0)
            |-> o_result.global_scale_x == 32'sd0)
        else $error("scale product of zero is not zero");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind transform_2d_compose_core t2dc_checker u_t2dc_checker (.*);

`default_nettype wire
